/* rtl/wpf_pkg.sv */
// ----------------------------------------------------------------------------
// wpf_pkg - shared types and constants for the windowed profit-factor score
// Sizes of the per-strategy windows and sums, opcodes and the channel words.
// ----------------------------------------------------------------------------
package wpf_pkg;

  // sizes
  localparam int STRATEGIES = 16;
  localparam int WINDOW     = 32;
  localparam int STRAT_W    = 4;
  localparam int SLOT_W     = 5;
  localparam int FILL_W     = 6;
  localparam int PNL_W      = 32;
  localparam int SUM_W      = 37;
  localparam int SCORE_W    = 16;
  localparam int ADDR_W     = STRAT_W + SLOT_W;
  localparam int DEPTH      = STRATEGIES * WINDOW;
  localparam int QCNT_W     = 5;

  // opcodes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // score limits
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 16'h7fff;
  localparam logic [SCORE_W-1:0] SCORE_ZERO = 16'h0000;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // input word
  typedef struct packed {
    logic                     opcode;
    logic [STRAT_W-1:0]       strategy;
    logic signed [PNL_W-1:0]  pnl;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [STRAT_W-1:0]         strategy_echo;
    logic signed [SCORE_W-1:0]  score;
    logic [FILL_W-1:0]          filled;
  } out_word_t;

  // ring write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PNL_W-1:0]  data;
  } ring_wr_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] profit;
    logic [SUM_W-1:0] loss;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SCORE_W-1:0] score;
  } div_rsp_t;

endpackage

/* rtl/wpf_ring.sv */
// ----------------------------------------------------------------------------
// wpf_ring - trade history memory
// One write port and one read port with registered read data, all windows.
// ----------------------------------------------------------------------------
module wpf_ring
  import wpf_pkg::*;
(
  input  logic              clk_i,
  input  ring_wr_t          wr_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [PNL_W-1:0]  rd_data_o
);

  logic [PNL_W-1:0] mem [DEPTH];
  logic [PNL_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/wpf_div.sv */
// ----------------------------------------------------------------------------
// wpf_div - iterative score divider
// Computes 16384*(P-L)/L truncated toward zero and clamped to Q0.15, one
// quotient bit per cycle with a shared subtract/compare.
// ----------------------------------------------------------------------------
module wpf_div
  import wpf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_CHK  = 3'd1;
  localparam logic [2:0] D_RUN  = 3'd2;
  localparam logic [2:0] D_FIN  = 3'd3;
  localparam logic [2:0] D_DONE = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [SUM_W-1:0]   rem_q, rem_d;
  logic [SUM_W-1:0]   div_q, div_d;
  logic [15:0]        lo_q, lo_d;
  logic [15:0]        quo_q, quo_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic [SCORE_W-1:0] res_q, res_d;

  logic [SUM_W:0]     p_minus_l;
  logic [SUM_W-1:0]   diff;
  logic [SUM_W:0]     shifted;
  logic [SUM_W:0]     trial;
  logic               ge;

  // magnitude of P-L at start
  assign p_minus_l = {1'b0, req_i.profit} - {1'b0, req_i.loss};
  assign diff      = p_minus_l[SUM_W] ? (req_i.loss - req_i.profit) : p_minus_l[SUM_W-1:0];

  // shared subtract and compare
  assign shifted = {rem_q, lo_q[15]};
  assign trial   = shifted - {1'b0, div_q};
  assign ge      = (state_q == D_CHK) ? (rem_q >= div_q) : !trial[SUM_W];

  // sequencer
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    div_d   = div_q;
    lo_d    = lo_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    res_d   = res_q;
    case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          if (req_i.loss == '0) begin
            res_d   = (req_i.profit != '0) ? SCORE_MAX : SCORE_ZERO;
            state_d = D_DONE;
          end else begin
            rem_d   = {2'b00, diff[SUM_W-1:2]};
            lo_d    = {diff[1:0], 14'd0};
            div_d   = req_i.loss;
            neg_d   = p_minus_l[SUM_W];
            state_d = D_CHK;
          end
        end
      end
      D_CHK: begin
        // quotient would not fit 16 bits: only reachable when positive
        if (ge) begin
          res_d   = SCORE_MAX;
          state_d = D_DONE;
        end else begin
          cnt_d   = '0;
          quo_d   = '0;
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        rem_d = ge ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];
        quo_d = {quo_q[14:0], ge};
        lo_d  = {lo_q[14:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1 >> 1) begin
          state_d = D_FIN;
        end
      end
      D_FIN: begin
        if (neg_q) begin
          res_d = ~quo_q + 16'd1;
        end else begin
          res_d = quo_q[15] ? SCORE_MAX : quo_q;
        end
        state_d = D_DONE;
      end
      D_DONE: begin
        state_d = D_IDLE;
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done  = (state_q == D_DONE);
  assign rsp_o.score = res_q;

endmodule

/* rtl/windowed_profit_factor_score.sv */
// ----------------------------------------------------------------------------
// windowed_profit_factor_score - sliding-window profit-factor score
// Keeps a window of recent trade results per strategy with running gross
// profit and loss sums, and reports a Q0.15 score (P-L)/(2L) per word.
//
//   channel | direction | handshake               | word
//   in      | input     | in_valid_i / in_stall_o | in_word_t
//   out     | output    | out_valid_o/ out_stall_i| out_word_t
//
// A record word reads the oldest slot, drops its value from the sums when the
// window is full, adds the new value and then starts the shared divider; a read
// word starts the divider at once. The 16-step quotient loop is skipped when
// there is no gross loss or when the quotient overflows the upper limit.
// The next word is accepted once the result has moved to the output register,
// even while that result is still stalled; a stalled result holds back the
// following one.
// Reset clears all sums, fill counts and write slots; the history memory needs
// no clearing since a read-back value only enters the sums once the window is full.
// ----------------------------------------------------------------------------
module windowed_profit_factor_score
  import wpf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_REM   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state_q, state_d;
  in_word_t           item_q;
  logic [SCORE_W-1:0] score_q;
  out_word_t          out_q;
  logic               out_valid_q;

  // per-strategy state
  logic [FILL_W-1:0]  fill_q   [STRATEGIES];
  logic [SLOT_W-1:0]  slot_q   [STRATEGIES];
  logic [SUM_W-1:0]   profit_q [STRATEGIES];
  logic [SUM_W-1:0]   loss_q   [STRATEGIES];

  logic [STRAT_W-1:0] s;
  logic [FILL_W-1:0]  fill_cur;
  logic [SLOT_W-1:0]  slot_cur;
  logic               in_acc;
  logic               out_free;

  ring_wr_t           ring_wr;
  logic [ADDR_W-1:0]  ring_raddr;
  logic [PNL_W-1:0]   ring_rdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [PNL_W-1:0]   val;
  logic               val_neg;
  logic [PNL_W:0]     val_ext;
  logic [PNL_W:0]     mag33;
  logic [SUM_W-1:0]   mag;
  logic [SUM_W-1:0]   sum_sel;
  logic [SUM_W-1:0]   sum_new;
  logic               sum_we;

  assign s        = item_q.strategy;
  assign fill_cur = fill_q[s];
  assign slot_cur = slot_q[s];
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != S_IDLE);

  // history memory
  assign ring_raddr   = {s, slot_cur};
  assign ring_wr.en   = (state_q == S_ADD);
  assign ring_wr.addr = {s, slot_cur};
  assign ring_wr.data = item_q.pnl;

  wpf_ring u_ring (
    .clk_i     (clk_i),
    .wr_i      (ring_wr),
    .rd_addr_i (ring_raddr),
    .rd_data_o (ring_rdata)
  );

  // score divider
  assign div_req.start  = (state_q == S_START);
  assign div_req.profit = profit_q[s];
  assign div_req.loss   = loss_q[s];

  wpf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared sum adder: drop the oldest value, then add the new one
  always_comb begin
    val     = (state_q == S_REM) ? ring_rdata : item_q.pnl;
    val_neg = val[PNL_W-1];
    val_ext = {val[PNL_W-1], val};
    mag33   = val_neg ? (~val_ext + 1'b1) : val_ext;
    mag     = {{(SUM_W-PNL_W-1){1'b0}}, mag33};
    sum_sel = val_neg ? loss_q[s] : profit_q[s];
    sum_new = (state_q == S_ADD) ? (sum_sel + mag) : (sum_sel - mag);
    sum_we  = (state_q == S_ADD) || ((state_q == S_REM) && (fill_cur == FILL_FULL));
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (in_word_i.opcode == OP_RECORD) ? S_RD : S_START;
        end
      end
      S_RD:    state_d = S_REM;
      S_REM:   state_d = S_ADD;
      S_ADD:   state_d = S_START;
      S_START: state_d = S_WAIT;
      S_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and per-strategy state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < STRATEGIES; i++) begin
        fill_q[i]   <= '0;
        slot_q[i]   <= '0;
        profit_q[i] <= '0;
        loss_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (sum_we) begin
        if (val_neg) begin
          loss_q[s] <= sum_new;
        end else begin
          profit_q[s] <= sum_new;
        end
      end
      if (state_q == S_ADD) begin
        if (fill_cur != FILL_FULL) begin
          fill_q[s] <= fill_cur + 1'b1;
        end
        slot_q[s] <= (slot_cur == SLOT_LAST) ? '0 : slot_cur + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_word_i;
    end
    if ((state_q == S_WAIT) && div_rsp.done) begin
      score_q <= div_rsp.score;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_q.strategy_echo <= s;
      out_q.score         <= score_q;
      out_q.filled        <= fill_cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* rtl/wpf_checker.sv */
// ----------------------------------------------------------------------------
// wpf_checker - port-level checks for the profit-factor score block
// Watches the two channels of the top level over time.
// ----------------------------------------------------------------------------
module wpf_checker
  import wpf_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // block is busy right after taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input word accepted while busy");

  // a new result leaves the block free for the next word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result shown while sequencer still busy");

  // an empty window scores zero and the fill never exceeds the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.filled <= FILL_FULL) &&
                    ((out_word_o.filled != '0) || (out_word_o.score == '0)))
    else $error("fill count or empty-window score wrong");

endmodule

bind windowed_profit_factor_score wpf_checker u_wpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
